FILE: rtl/ssi_pkg.sv
// Shared constants for the segment/sphere intersection pipeline.
// No dependencies; imported by ssi_vec, ssi_cmp and segment_sphere_intersect.
package ssi_pkg;

    localparam int RADIUS_BITS = 15;
    localparam int RSQ_BITS    = 2 * RADIUS_BITS;

    // Register stages from request to result: three in ssi_vec, four in ssi_cmp.
    localparam int VEC_STAGES  = 3;
    localparam int CMP_STAGES  = 4;
    localparam int PIPE_DEPTH  = VEC_STAGES + CMP_STAGES;

endpackage

FILE: rtl/ssi_vec.sv
// Vector front end: edge vectors, pairwise products and their sums.
// Three register stages, all advanced by en. Depends on ssi_pkg.
module ssi_vec #(
    parameter int COORD_BITS = 16
) (
    input  logic                                    clk,
    input  logic                                    en,
    input  logic signed [COORD_BITS-1:0]            a_x,
    input  logic signed [COORD_BITS-1:0]            a_y,
    input  logic signed [COORD_BITS-1:0]            a_z,
    input  logic signed [COORD_BITS-1:0]            b_x,
    input  logic signed [COORD_BITS-1:0]            b_y,
    input  logic signed [COORD_BITS-1:0]            b_z,
    input  logic signed [COORD_BITS-1:0]            c_x,
    input  logic signed [COORD_BITS-1:0]            c_y,
    input  logic signed [COORD_BITS-1:0]            c_z,
    input  logic        [ssi_pkg::RADIUS_BITS-1:0]  radius,
    output logic        [2*COORD_BITS+1:0]          lensq,
    output logic signed [2*COORD_BITS+2:0]          dot,
    output logic        [2*COORD_BITS+1:0]          dist_a,
    output logic        [2*COORD_BITS+1:0]          dist_b,
    output logic        [2*COORD_BITS+1:0]          kmag [3],
    output logic        [ssi_pkg::RSQ_BITS-1:0]     rsq
);
    import ssi_pkg::*;

    localparam int N  = COORD_BITS;
    localparam int D  = N + 1;        // coordinate difference
    localparam int P  = 2 * D;        // product of two differences
    localparam int LW = 2 * N + 2;    // sum of squares, unsigned
    localparam int DW = 2 * N + 3;    // signed sums

    logic signed [N-1:0] a_in [3];
    logic signed [N-1:0] b_in [3];
    logic signed [N-1:0] c_in [3];

    // stage 1: differences
    logic signed [D-1:0] d_next [3], d_reg [3];   // B - A
    logic signed [D-1:0] w_next [3], w_reg [3];   // C - A
    logic signed [D-1:0] e_next [3], e_reg [3];   // C - B
    logic [RADIUS_BITS-1:0] radius_next, radius_reg;

    // stage 2: products
    logic signed [P-1:0] dd_next [3], dd_reg [3];
    logic signed [P-1:0] wd_next [3], wd_reg [3];
    logic signed [P-1:0] ww_next [3], ww_reg [3];
    logic signed [P-1:0] ee_next [3], ee_reg [3];
    logic signed [P-1:0] pa_next [3], pa_reg [3];
    logic signed [P-1:0] pb_next [3], pb_reg [3];
    logic [RSQ_BITS-1:0] rsq_next, rsq_reg;

    // stage 3: sums
    logic signed [DW-1:0] k_diff [3];
    logic [LW-1:0]        lensq_next, lensq_reg;
    logic signed [DW-1:0] dot_next, dot_reg;
    logic [LW-1:0]        dist_a_next, dist_a_reg;
    logic [LW-1:0]        dist_b_next, dist_b_reg;
    logic [LW-1:0]        kmag_next [3], kmag_reg [3];
    logic [RSQ_BITS-1:0]  rsq3_next, rsq3_reg;

    assign a_in[0] = a_x;
    assign a_in[1] = a_y;
    assign a_in[2] = a_z;
    assign b_in[0] = b_x;
    assign b_in[1] = b_y;
    assign b_in[2] = b_z;
    assign c_in[0] = c_x;
    assign c_in[1] = c_y;
    assign c_in[2] = c_z;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            d_next[i] = D'(b_in[i]) - D'(a_in[i]);
            w_next[i] = D'(c_in[i]) - D'(a_in[i]);
            e_next[i] = D'(c_in[i]) - D'(b_in[i]);
        end
        radius_next = radius;
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            dd_next[i] = d_reg[i] * d_reg[i];
            wd_next[i] = w_reg[i] * d_reg[i];
            ww_next[i] = w_reg[i] * w_reg[i];
            ee_next[i] = e_reg[i] * e_reg[i];
        end
        // cross product (C-A) x (B-A), as two terms per axis
        pa_next[0] = w_reg[1] * d_reg[2];
        pb_next[0] = w_reg[2] * d_reg[1];
        pa_next[1] = w_reg[2] * d_reg[0];
        pb_next[1] = w_reg[0] * d_reg[2];
        pa_next[2] = w_reg[0] * d_reg[1];
        pb_next[2] = w_reg[1] * d_reg[0];
        rsq_next   = RSQ_BITS'(radius_reg) * RSQ_BITS'(radius_reg);
    end

    always_comb
    begin
        lensq_next  = $unsigned(dd_reg[0]) + $unsigned(dd_reg[1]) + $unsigned(dd_reg[2]);
        dot_next    = DW'(wd_reg[0]) + DW'(wd_reg[1]) + DW'(wd_reg[2]);
        dist_a_next = $unsigned(ww_reg[0]) + $unsigned(ww_reg[1]) + $unsigned(ww_reg[2]);
        dist_b_next = $unsigned(ee_reg[0]) + $unsigned(ee_reg[1]) + $unsigned(ee_reg[2]);
        for (int i = 0; i < 3; i++)
        begin
            k_diff[i]    = DW'(pa_reg[i]) - DW'(pb_reg[i]);
            kmag_next[i] = k_diff[i][DW-1] ? LW'(-k_diff[i]) : LW'(k_diff[i]);
        end
        rsq3_next = rsq_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_reg       <= d_next;
            w_reg       <= w_next;
            e_reg       <= e_next;
            radius_reg  <= radius_next;
            dd_reg      <= dd_next;
            wd_reg      <= wd_next;
            ww_reg      <= ww_next;
            ee_reg      <= ee_next;
            pa_reg      <= pa_next;
            pb_reg      <= pb_next;
            rsq_reg     <= rsq_next;
            lensq_reg   <= lensq_next;
            dot_reg     <= dot_next;
            dist_a_reg  <= dist_a_next;
            dist_b_reg  <= dist_b_next;
            kmag_reg    <= kmag_next;
            rsq3_reg    <= rsq3_next;
        end
    end

    assign lensq  = lensq_reg;
    assign dot    = dot_reg;
    assign dist_a = dist_a_reg;
    assign dist_b = dist_b_reg;
    assign kmag   = kmag_reg;
    assign rsq    = rsq3_reg;

endmodule

FILE: rtl/ssi_cmp.sv
// Wide back end: segment range test, split squaring of the cross product,
// r^2*|d|^2 and the final compare. Four register stages. Depends on ssi_pkg.
module ssi_cmp #(
    parameter int COORD_BITS = 16
) (
    input  logic                                 clk,
    input  logic                                 en,
    input  logic        [2*COORD_BITS+1:0]       lensq,
    input  logic signed [2*COORD_BITS+2:0]       dot,
    input  logic        [2*COORD_BITS+1:0]       dist_a,
    input  logic        [2*COORD_BITS+1:0]       dist_b,
    input  logic        [2*COORD_BITS+1:0]       kmag [3],
    input  logic        [ssi_pkg::RSQ_BITS-1:0]  rsq,
    output logic                                 hit
);
    import ssi_pkg::*;

    localparam int LW = 2 * COORD_BITS + 2;
    localparam int DW = LW + 1;
    localparam int H  = LW / 2;                         // half of a magnitude
    localparam int CW = (LW > RSQ_BITS) ? LW : RSQ_BITS;
    localparam int WW = (4 * H > 2 * COORD_BITS + 32) ? 4 * H : 2 * COORD_BITS + 32;
    localparam int RW = RSQ_BITS + H;

    // stage 4
    logic            zero_next, zero4_reg;
    logic            outside_next, outside4_reg;
    logic            near_next, near4_reg;
    logic [2*H-1:0]  hh_next [3], hh_reg [3];
    logic [2*H-1:0]  hl_next [3], hl_reg [3];
    logic [2*H-1:0]  ll_next [3], ll_reg [3];
    logic [RW-1:0]   rl_next, rl_reg;
    logic [RW-1:0]   rh_next, rh_reg;

    // stage 5
    logic [WW-1:0]   sq_next [3], sq_reg [3];
    logic [WW-1:0]   rhs_next, rhs5_reg;
    logic            zero5_reg, outside5_reg, near5_reg;

    // stage 6
    logic [WW-1:0]   lhs_next, lhs_reg;
    logic [WW-1:0]   rhs6_reg;
    logic            zero6_reg, outside6_reg, near6_reg;

    // stage 7
    logic            hit_next, hit_reg;

    always_comb
    begin
        zero_next    = (lensq == '0);
        outside_next = dot[DW-1] || (dot > $signed({1'b0, lensq}));
        near_next    = (CW'(dist_a) <= CW'(rsq)) || (CW'(dist_b) <= CW'(rsq));
        for (int i = 0; i < 3; i++)
        begin
            hh_next[i] = (2*H)'(kmag[i][LW-1:H]) * (2*H)'(kmag[i][LW-1:H]);
            hl_next[i] = (2*H)'(kmag[i][LW-1:H]) * (2*H)'(kmag[i][H-1:0]);
            ll_next[i] = (2*H)'(kmag[i][H-1:0]) * (2*H)'(kmag[i][H-1:0]);
        end
        rl_next = RW'(rsq) * RW'(lensq[H-1:0]);
        rh_next = RW'(rsq) * RW'(lensq[LW-1:H]);
    end

    always_comb
    begin
        // hi^2 and lo^2 do not overlap; the cross term counts twice
        for (int i = 0; i < 3; i++)
        begin
            sq_next[i] = WW'({hh_reg[i], ll_reg[i]}) + (WW'(hl_reg[i]) << (H + 1));
        end
        rhs_next = (WW'(rh_reg) << H) + WW'(rl_reg);
    end

    always_comb
    begin
        lhs_next = sq_reg[0] + sq_reg[1] + sq_reg[2];
    end

    always_comb
    begin
        priority if (zero6_reg)
            hit_next = 1'b0;
        else if (outside6_reg)
            hit_next = near6_reg;
        else
            hit_next = (lhs_reg <= rhs6_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            zero4_reg    <= zero_next;
            outside4_reg <= outside_next;
            near4_reg    <= near_next;
            hh_reg       <= hh_next;
            hl_reg       <= hl_next;
            ll_reg       <= ll_next;
            rl_reg       <= rl_next;
            rh_reg       <= rh_next;

            sq_reg       <= sq_next;
            rhs5_reg     <= rhs_next;
            zero5_reg    <= zero4_reg;
            outside5_reg <= outside4_reg;
            near5_reg    <= near4_reg;

            lhs_reg      <= lhs_next;
            rhs6_reg     <= rhs5_reg;
            zero6_reg    <= zero5_reg;
            outside6_reg <= outside5_reg;
            near6_reg    <= near5_reg;

            hit_reg      <= hit_next;
        end
    end

    assign hit = hit_reg;

endmodule

FILE: rtl/segment_sphere_intersect.sv
// Top level of the segment/sphere hit test: valid tracking and stall control.
// Instantiates ssi_vec and ssi_cmp; depends on ssi_pkg.
//
// Usage:
//   Input channel in_valid/in_ready carries one request: segment end points
//   A (a_x..a_z), B (b_x..b_z), sphere centre C (c_x..c_z) and radius.
//   Output channel out_valid/out_ready returns one hit flag per request, in
//   request order. hit is 1 when some point of the segment lies within
//   radius of C, boundary included; a zero-length segment never hits.
//   A request passes through three stages of vector products and sums,
//   then four stages of split squaring, wide summing and compare.
//   Throughput: one request per cycle while the output is not stalled;
//   nothing in the seven-stage pipeline links one request to the next.
//   Stall: while out_valid is high and out_ready is low the whole pipeline
//   holds and in_ready drops; no request is lost or repeated.
//   Reset: rst_n clears all valid bits; the pipeline is empty and ready
//   right after reset.
module segment_sphere_intersect #(
    parameter int COORD_BITS = 16
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    in_valid,
    output logic                                    in_ready,
    input  logic signed [COORD_BITS-1:0]            a_x,
    input  logic signed [COORD_BITS-1:0]            a_y,
    input  logic signed [COORD_BITS-1:0]            a_z,
    input  logic signed [COORD_BITS-1:0]            b_x,
    input  logic signed [COORD_BITS-1:0]            b_y,
    input  logic signed [COORD_BITS-1:0]            b_z,
    input  logic signed [COORD_BITS-1:0]            c_x,
    input  logic signed [COORD_BITS-1:0]            c_y,
    input  logic signed [COORD_BITS-1:0]            c_z,
    input  logic        [ssi_pkg::RADIUS_BITS-1:0]  radius,
    output logic                                    out_valid,
    input  logic                                    out_ready,
    output logic                                    hit
);
    import ssi_pkg::*;

    localparam int LW = 2 * COORD_BITS + 2;
    localparam int DW = LW + 1;

    logic                  en;
    logic [PIPE_DEPTH-1:0] vld_next, vld_reg;

    logic [LW-1:0]         lensq;
    logic signed [DW-1:0]  dot;
    logic [LW-1:0]         dist_a;
    logic [LW-1:0]         dist_b;
    logic [LW-1:0]         kmag [3];
    logic [RSQ_BITS-1:0]   rsq;

    // advance everything unless a finished result is waiting and out_ready is low
    assign en        = !vld_reg[PIPE_DEPTH-1] || out_ready;
    assign in_ready  = en;
    assign out_valid = vld_reg[PIPE_DEPTH-1];

    always_comb
    begin
        vld_next = en ? {vld_reg[PIPE_DEPTH-2:0], in_valid} : vld_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= vld_next;
    end

    ssi_vec #(
        .COORD_BITS (COORD_BITS)
    ) u_vec (
        .clk    (clk),
        .en     (en),
        .a_x    (a_x),
        .a_y    (a_y),
        .a_z    (a_z),
        .b_x    (b_x),
        .b_y    (b_y),
        .b_z    (b_z),
        .c_x    (c_x),
        .c_y    (c_y),
        .c_z    (c_z),
        .radius (radius),
        .lensq  (lensq),
        .dot    (dot),
        .dist_a (dist_a),
        .dist_b (dist_b),
        .kmag   (kmag),
        .rsq    (rsq)
    );

    ssi_cmp #(
        .COORD_BITS (COORD_BITS)
    ) u_cmp (
        .clk    (clk),
        .en     (en),
        .lensq  (lensq),
        .dot    (dot),
        .dist_a (dist_a),
        .dist_b (dist_b),
        .kmag   (kmag),
        .rsq    (rsq),
        .hit    (hit)
    );

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(vld_reg))
        else $error("valid bits moved during a stall");

    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> vld_reg[0])
        else $error("accepted request missing from first stage");

    a_advance_shifts: assert property (@(posedge clk) disable iff (!rst_n)
        en |=> vld_reg[PIPE_DEPTH-1:1] == $past(vld_reg[PIPE_DEPTH-2:0]))
        else $error("valid bits did not advance one stage");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled while output stage empty");

endmodule

FILE: tb/sv/ssi_tb_pkg.sv
`timescale 1ns / 1ps
// Request record and hit scoreboard for the segment/sphere intersection bench.
// Depends on ssi_pkg for the radius width; used by tb_segment_sphere_intersect.
package ssi_tb_pkg;

    localparam int COORD_W = 16;

    typedef struct {
        logic signed [COORD_W-1:0]             a_x, a_y, a_z;
        logic signed [COORD_W-1:0]             b_x, b_y, b_z;
        logic signed [COORD_W-1:0]             c_x, c_y, c_z;
        logic        [ssi_pkg::RADIUS_BITS-1:0] radius;
    } seg_query_t;

    class hit_scoreboard;
        bit pending_hits[$];
        int mismatches;
        int results_checked;
        int hits_seen;
        int zero_length_seen;
        int outside_seen;

        // Exact integer form of the hit test; the perpendicular case needs 128 bits.
        function bit segment_hits(seg_query_t q);
            longint     dx, dy, dz, wx, wy, wz, ex, ey, ez;
            longint     kx, ky, kz, lensq, proj, rsq, dist_a, dist_b;
            logic [127:0] mx, my, mz, lhs, rhs, wide_rsq, wide_len;
            dx = longint'(q.b_x) - longint'(q.a_x);
            dy = longint'(q.b_y) - longint'(q.a_y);
            dz = longint'(q.b_z) - longint'(q.a_z);
            wx = longint'(q.c_x) - longint'(q.a_x);
            wy = longint'(q.c_y) - longint'(q.a_y);
            wz = longint'(q.c_z) - longint'(q.a_z);
            rsq = longint'(q.radius) * longint'(q.radius);
            lensq = dx * dx + dy * dy + dz * dz;
            proj = wx * dx + wy * dy + wz * dz;
            if (lensq == 0)
            begin
                zero_length_seen++;
                return 1'b0;
            end
            if (proj < 0 || proj > lensq)
            begin
                // closest point of the line is past an end: test both ends
                outside_seen++;
                ex = longint'(q.c_x) - longint'(q.b_x);
                ey = longint'(q.c_y) - longint'(q.b_y);
                ez = longint'(q.c_z) - longint'(q.b_z);
                dist_a = wx * wx + wy * wy + wz * wz;
                dist_b = ex * ex + ey * ey + ez * ez;
                return (dist_a <= rsq) || (dist_b <= rsq);
            end
            kx = wy * dz - wz * dy;
            ky = wz * dx - wx * dz;
            kz = wx * dy - wy * dx;
            mx = (kx < 0) ? 128'(-kx) : 128'(kx);
            my = (ky < 0) ? 128'(-ky) : 128'(ky);
            mz = (kz < 0) ? 128'(-kz) : 128'(kz);
            lhs = mx * mx + my * my + mz * mz;
            wide_rsq = 128'(rsq);
            wide_len = 128'(lensq);
            rhs = wide_rsq * wide_len;
            return lhs <= rhs;
        endfunction

        function void note_request(seg_query_t q);
            pending_hits.push_back(segment_hits(q));
        endfunction

        task report_mismatch(string msg);
            mismatches++;
            $display("[%0t] mismatch: %s", $realtime, msg);
        endtask

        task check_result(logic got);
            bit want;
            results_checked++;
            if (pending_hits.size() == 0)
            begin
                report_mismatch($sformatf("hit=%b with no request outstanding", got));
                return;
            end
            want = pending_hits.pop_front();
            if (got !== want)
                report_mismatch($sformatf("result %0d: hit=%b, want %b",
                                          results_checked, got, want));
            if (got === 1'b1)
                hits_seen++;
        endtask

        function int outstanding();
            return pending_hits.size();
        endfunction
    endclass

endpackage

FILE: tb/sv/tb_segment_sphere_intersect.sv
`timescale 1ns / 1ps
// Top-level bench for segment_sphere_intersect: directed and random requests,
// random stalls on both channels. Depends on ssi_pkg and ssi_tb_pkg.
module tb_segment_sphere_intersect;
    import ssi_tb_pkg::*;

    localparam int RANDOM_REQUESTS = 630;
    localparam int IDLE_LIMIT      = 4000;
    localparam int HOLD_CYCLES     = 150;

    logic                              clk = 1'b0;
    logic                              rst_n;
    logic                              in_valid;
    logic                              in_ready;
    logic signed [COORD_W-1:0]         a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z;
    logic [ssi_pkg::RADIUS_BITS-1:0]   radius;
    logic                              out_valid;
    logic                              out_ready;
    logic                              hit;

    hit_scoreboard sb = new();
    bit tx_steady;
    bit rx_steady;
    int requests_sent;
    int input_stalls;

    segment_sphere_intersect #(.COORD_BITS(COORD_W)) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .a_x       (a_x),
        .a_y       (a_y),
        .a_z       (a_z),
        .b_x       (b_x),
        .b_y       (b_y),
        .b_z       (b_z),
        .c_x       (c_x),
        .c_y       (c_y),
        .c_z       (c_z),
        .radius    (radius),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .hit       (hit)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_query(input seg_query_t q);
        int gap;
        gap = tx_steady ? 0 : $urandom_range(0, 14);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        a_x <= q.a_x;  a_y <= q.a_y;  a_z <= q.a_z;
        b_x <= q.b_x;  b_y <= q.b_y;  b_z <= q.b_z;
        c_x <= q.c_x;  c_y <= q.c_y;  c_z <= q.c_z;
        radius <= q.radius;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_request(q);
        requests_sent++;
        @(negedge clk);
    endtask

    task automatic send_points(input int ax, ay, az, bx, by, bz, cx, cy, cz, r);
        seg_query_t q;
        q.a_x = COORD_W'(ax);  q.a_y = COORD_W'(ay);  q.a_z = COORD_W'(az);
        q.b_x = COORD_W'(bx);  q.b_y = COORD_W'(by);  q.b_z = COORD_W'(bz);
        q.c_x = COORD_W'(cx);  q.c_y = COORD_W'(cy);  q.c_z = COORD_W'(cz);
        q.radius = 15'(r);
        send_query(q);
    endtask

    function automatic logic signed [COORD_W-1:0] pick_corner();
        case ($urandom_range(0, 5))
            0: return -16'sd32768;
            1: return 16'sd32767;
            2: return 16'sd0;
            3: return -16'sd1;
            4: return 16'sd1;
            default: return 16'($urandom());
        endcase
    endfunction

    function automatic int small_coord();
        return int'($urandom_range(0, 32)) - 16;
    endfunction

    task automatic run_directed();
        // zero-length segment, even with A inside the sphere
        send_points(5, 5, 5, 5, 5, 5, 5, 5, 5, 100);
        send_points(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768,
                    -32768, 32767);
        // zero radius: on the segment, just off it, at either end
        send_points(0, 0, 0, 10, 0, 0, 5, 0, 0, 0);
        send_points(0, 0, 0, 10, 0, 0, 5, 1, 0, 0);
        send_points(0, 0, 0, 10, 0, 0, 10, 0, 0, 0);
        send_points(0, 0, 0, 10, 0, 0, 0, 0, 0, 0);
        // closest point before A, then past B, on the boundary and just outside it
        send_points(0, 0, 0, 10, 0, 0, -3, 4, 0, 5);
        send_points(0, 0, 0, 10, 0, 0, -3, 4, 0, 4);
        send_points(0, 0, 0, 10, 0, 0, 13, 4, 0, 5);
        send_points(0, 0, 0, 10, 0, 0, 13, 4, 0, 4);
        // perpendicular distance exactly r, then r-1
        send_points(0, 0, 0, 10, 0, 0, 5, 7, 0, 7);
        send_points(0, 0, 0, 10, 0, 0, 5, 7, 0, 6);
        // full-range coordinates
        send_points(-32768, -32768, -32768, 32767, 32767, 32767, 32767, -32768, 32767,
                    32767);
        send_points(-32768, -32768, -32768, 32767, 32767, 32767, 32767, -32768, 32767, 0);
        send_points(32767, 32767, 32767, -32768, -32768, -32768, 0, 0, 0, 0);
        send_points(-32768, 32767, -32768, 32767, -32768, 32767, -32768, -32768, -32768,
                    32767);
        send_points(0, 0, 0, 1, 0, 0, 32767, 32767, 32767, 32767);
        send_points(-32768, 0, 0, 32767, 0, 0, 0, 32767, 0, 32767);
        send_points(-32768, 0, 0, 32767, 0, 0, 0, -32768, 0, 32767);
        send_points(0, 0, -32768, 0, 0, -32767, 0, 0, 32767, 32767);
        send_points(1, 2, 3, -4, 5, -6, 0, 0, 0, 7);
    endtask

    task automatic run_random();
        seg_query_t q;
        int ax, ay, az, dx, dy, dz, k;
        for (int n = 0; n < RANDOM_REQUESTS; n++)
        begin
            if (n % 40 == 0)
                tx_steady = ($urandom_range(0, 3) == 0);
            case ($urandom_range(0, 9))
                0, 1, 2, 3:
                begin
                    q.a_x = 16'($urandom());  q.a_y = 16'($urandom());
                    q.a_z = 16'($urandom());  q.b_x = 16'($urandom());
                    q.b_y = 16'($urandom());  q.b_z = 16'($urandom());
                    q.c_x = 16'($urandom());  q.c_y = 16'($urandom());
                    q.c_z = 16'($urandom());  q.radius = 15'($urandom());
                end
                4, 5:
                begin
                    // small lattice: many exact boundary cases
                    q.a_x = COORD_W'(small_coord());
                    q.a_y = COORD_W'(small_coord());
                    q.a_z = COORD_W'(small_coord());
                    q.b_x = COORD_W'(small_coord());
                    q.b_y = COORD_W'(small_coord());
                    q.b_z = COORD_W'(small_coord());
                    q.c_x = COORD_W'(small_coord());
                    q.c_y = COORD_W'(small_coord());
                    q.c_z = COORD_W'(small_coord());
                    q.radius = 15'($urandom_range(0, 20));
                end
                6:
                begin
                    // centre on the segment at a lattice point, sometimes nudged off
                    ax = int'($urandom_range(0, 16000)) - 8000;
                    ay = int'($urandom_range(0, 16000)) - 8000;
                    az = int'($urandom_range(0, 16000)) - 8000;
                    dx = int'($urandom_range(0, 4000)) - 2000;
                    dy = int'($urandom_range(0, 4000)) - 2000;
                    dz = int'($urandom_range(0, 4000)) - 2000;
                    k = $urandom_range(0, 4);
                    q.a_x = COORD_W'(ax);  q.a_y = COORD_W'(ay);  q.a_z = COORD_W'(az);
                    q.b_x = COORD_W'(ax + 4 * dx);
                    q.b_y = COORD_W'(ay + 4 * dy);
                    q.b_z = COORD_W'(az + 4 * dz);
                    q.c_x = COORD_W'(ax + k * dx + int'($urandom_range(0, 2)) - 1);
                    q.c_y = COORD_W'(ay + k * dy);
                    q.c_z = COORD_W'(az + k * dz);
                    q.radius = 15'($urandom_range(0, 2));
                end
                7:
                begin
                    q.a_x = 16'($urandom());  q.a_y = 16'($urandom());
                    q.a_z = 16'($urandom());
                    q.b_x = q.a_x;  q.b_y = q.a_y;  q.b_z = q.a_z;
                    q.c_x = COORD_W'(q.a_x + small_coord());
                    q.c_y = q.a_y;  q.c_z = q.a_z;
                    q.radius = 15'($urandom());
                end
                default:
                begin
                    q.a_x = pick_corner();  q.a_y = pick_corner();  q.a_z = pick_corner();
                    q.b_x = pick_corner();  q.b_y = pick_corner();  q.b_z = pick_corner();
                    q.c_x = pick_corner();  q.c_y = pick_corner();  q.c_z = pick_corner();
                    case ($urandom_range(0, 2))
                        0: q.radius = '0;
                        1: q.radius = '1;
                        default: q.radius = 15'($urandom());
                    endcase
                end
            endcase
            send_query(q);
        end
    endtask

    // Result side: random stalls, steady stretches and two long hold-offs.
    initial
    begin
        int stall;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (sb.results_checked % 40 == 0)
                rx_steady = ($urandom_range(0, 3) == 0);
            if (sb.results_checked == 120 || sb.results_checked == 420)
                stall = HOLD_CYCLES;
            else
                stall = rx_steady ? 0 : $urandom_range(0, 14);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (!out_valid);
            sb.check_result(hit);
        end
    end

    // Watchdog: end the run after too many cycles without a handshake.
    initial
    begin
        int idle;
        idle = 0;
        while (idle < IDLE_LIMIT)
        begin
            @(posedge clk);
            if (rst_n && in_valid && !in_ready)
                input_stalls++;
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle = 0;
            else
                idle++;
        end
        $display("timeout: no handshake for %0d cycles", IDLE_LIMIT);
        $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        a_x = '0;  a_y = '0;  a_z = '0;
        b_x = '0;  b_y = '0;  b_z = '0;
        c_x = '0;  c_y = '0;  c_z = '0;
        radius = '0;
        tx_steady = 1'b0;
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        run_directed();
        run_random();
        in_valid <= 1'b0;
        while (sb.outstanding() != 0)
            @(posedge clk);
        // catch any stray result after the last one
        repeat (ssi_pkg::PIPE_DEPTH + 8) @(posedge clk);
        $display("covered %0d requests, %0d results: %0d hits, %0d zero-length, %0d past an end",
                 requests_sent, sb.results_checked, sb.hits_seen, sb.zero_length_seen,
                 sb.outside_seen);
        $display("input held off by a full pipeline for %0d cycles; %0d mismatches",
                 input_stalls, sb.mismatches);
        if (sb.mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

FILE: sim.f
rtl/ssi_pkg.sv
rtl/ssi_vec.sv
rtl/ssi_cmp.sv
rtl/segment_sphere_intersect.sv
tb/sv/ssi_tb_pkg.sv
tb/sv/tb_segment_sphere_intersect.sv
